@@ design/ecc_scalar_multiply_core_macros.svh @@
// Assertion macros shared by the ECC scalar multiply core.
`ifndef ECC_SCALAR_MULTIPLY_CORE_MACROS_SVH
`define ECC_SCALAR_MULTIPLY_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ECSM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecsm: same-cycle implication violated");
// Next-cycle implication.
`define ECSM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ecsm: next-cycle implication violated");
`else
`define ECSM_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ECSM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ design/ecsm_pkg.sv @@
// Types and codes shared by the ECC scalar multiply core.
`timescale 1ns / 1ps
package ecsm_pkg;

   localparam int COORD_BITS  = 16;
   localparam int SCALAR_BITS_IN = 32;

   // datapath operations
   localparam logic [3:0] OP_NOP   = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_MOV   = 4'd2;
   localparam logic [3:0] OP_ADD   = 4'd3;
   localparam logic [3:0] OP_SUB   = 4'd4;
   localparam logic [3:0] OP_MUL   = 4'd5;
   localparam logic [3:0] OP_DIV   = 4'd6;
   localparam logic [3:0] OP_RED   = 4'd7;
   localparam logic [3:0] OP_ONE   = 4'd8;
   localparam logic [3:0] OP_SHIFT = 4'd9;

   // operand / destination register ids
   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_P    = 5'd1;
   localparam logic [4:0] REG_CA   = 5'd2;
   localparam logic [4:0] REG_A    = 5'd3;
   localparam logic [4:0] REG_BX   = 5'd4;
   localparam logic [4:0] REG_BY   = 5'd5;
   localparam logic [4:0] REG_AX   = 5'd6;
   localparam logic [4:0] REG_AY   = 5'd7;
   localparam logic [4:0] REG_T0   = 5'd8;
   localparam logic [4:0] REG_T1   = 5'd9;
   localparam logic [4:0] REG_T2   = 5'd10;
   localparam logic [4:0] REG_LAM  = 5'd11;
   localparam logic [4:0] REG_R0   = 5'd12;
   localparam logic [4:0] REG_R1   = 5'd13;
   localparam logic [4:0] REG_S0   = 5'd14;
   localparam logic [4:0] REG_S1   = 5'd15;
   localparam logic [4:0] REG_Q    = 5'd16;

   typedef struct packed {
      logic [COORD_BITS-1:0]     point_x;
      logic [COORD_BITS-1:0]     point_y;
      logic                      point_is_infinity;
      logic signed [SCALAR_BITS_IN-1:0] scalar;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] result_x;
      logic [COORD_BITS-1:0] result_y;
      logic                  result_is_infinity;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic [4:0] src_a;
      logic [4:0] src_b;
      logic [4:0] dst;
      logic       go;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic a_zero;
      logic a_eq_b;
      logic mag_zero;
      logic mag_lsb;
      logic neg;
      logic p_small;
   } status_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic result_inf;
   } report_type;

endpackage

@@ design/ecc_scalar_multiply_core.sv @@
// Top level of the ECC scalar multiply core: command port, register port, result strobe.
`timescale 1ns / 1ps
`include "ecc_scalar_multiply_core_macros.svh"
// Computes k*P on y^2 = x^3 + a*x + b over GF(p) by right-to-left double-and-add.
// Raise start with the point and scalar on req_payload; the transfer happens at an
// edge where start is high and busy is low, and busy stays high until the result
// is issued. The result appears on rsp_payload for exactly one cycle with
// rsp_valid high; the receiver cannot stall it, so capture it then. One item is
// worked at a time. Each bit of |k| costs one point doubling plus one point
// addition when the bit is set; each of those that is not settled by a special
// case (a point at infinity, equal x, a zero y) runs one extended-Euclid inverse.
// Field multiplies and divides run on two separate serial units in the datapath,
// each retiring one bit a cycle while the sequencer waits for it. The scalar loop
// runs up to the highest set bit of |k|, after the operands are reduced. A zero
// scalar pays only that reduction; an input at infinity or a modulus below two
// returns infinity without it.
// Write field_prime and curve_a only while busy is low.
module ecc_scalar_multiply_core #(
   parameter int FIELD_BITS  = 16,
   parameter int SCALAR_BITS = 32,
   parameter int CSR_BITS    = (FIELD_BITS > 32) ? 64 : 32,
   parameter int ADDR_BITS   = (FIELD_BITS > 32) ? 4 : 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ecsm_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   output ecsm_pkg::rsp_type     rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [CSR_BITS-1:0]   pwdata,
   output logic [CSR_BITS-1:0]   prdata,
   output logic                  pready
);
   import ecsm_pkg::*;

   localparam logic CSR_PRIME   = 1'b0;
   localparam logic CSR_CURVE_A = 1'b1;

   logic [FIELD_BITS-1:0] prime_ff, curve_a_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   cmd_type    cmd;
   status_type status;
   report_type report;

   logic [63:0] x_wide, y_wide, s_wide, ax_wide, ay_wide;
   logic [FIELD_BITS-1:0]  px, py, acc_x, acc_y;
   logic [SCALAR_BITS-1:0] scalar_raw;
   logic                   rsp_inf_strobe, rsp_coord_zero;

   // resize the fixed-width payload fields to the datapath widths
   always_comb begin
      x_wide     = 64'(req_payload.point_x);
      y_wide     = 64'(req_payload.point_y);
      s_wide     = 64'($unsigned(req_payload.scalar));
      px         = x_wide[FIELD_BITS-1:0];
      py         = y_wide[FIELD_BITS-1:0];
      scalar_raw = s_wide[SCALAR_BITS-1:0];
      ax_wide    = 64'(acc_x);
      ay_wide    = 64'(acc_y);
   end

   // register port: write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff   <= FIELD_BITS'(17);
         curve_a_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (paddr[ADDR_BITS-1])
            CSR_PRIME:   prime_ff   <= pwdata[FIELD_BITS-1:0];
            CSR_CURVE_A: curve_a_ff <= pwdata[FIELD_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign prdata = (paddr[ADDR_BITS-1] == CSR_CURVE_A) ? CSR_BITS'(curve_a_ff)
                                                       : CSR_BITS'(prime_ff);
   assign pready = 1'b1;

   ecsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .point_inf (req_payload.point_is_infinity),
      .status    (status),
      .cmd       (cmd),
      .report    (report)
   );

   ecsm_datapath #(
      .FIELD_BITS  (FIELD_BITS),
      .SCALAR_BITS (SCALAR_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .prime      (prime_ff),
      .curve_a    (curve_a_ff),
      .px         (px),
      .py         (py),
      .scalar_raw (scalar_raw),
      .status     (status),
      .acc_x      (acc_x),
      .acc_y      (acc_y)
   );

   // hold the result for one strobe cycle; infinity reads as zero coordinates
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= report.done;
      end
      if (report.done) begin
         rsp_ff.result_is_infinity <= report.result_inf;
         rsp_ff.result_x <= report.result_inf ? '0 : ax_wide[COORD_BITS-1:0];
         rsp_ff.result_y <= report.result_inf ? '0 : ay_wide[COORD_BITS-1:0];
      end
   end

   assign busy        = report.busy;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign rsp_inf_strobe = rsp_valid && rsp_payload.result_is_infinity;
   assign rsp_coord_zero = (rsp_payload.result_x == '0) && (rsp_payload.result_y == '0);

   `ECSM_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ECSM_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `ECSM_ASSERT_IMPLY(a_inf_zero, clock, reset, rsp_inf_strobe, rsp_coord_zero)

endmodule

@@ design/ecsm_datapath.sv @@
// Field arithmetic datapath: operand registers, modular add/sub, serial multiply and divide.
`timescale 1ns / 1ps
module ecsm_datapath #(
   parameter int FIELD_BITS  = 16,
   parameter int SCALAR_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ecsm_pkg::cmd_type        cmd,
   input  logic [FIELD_BITS-1:0]    prime,
   input  logic [FIELD_BITS-1:0]    curve_a,
   input  logic [FIELD_BITS-1:0]    px,
   input  logic [FIELD_BITS-1:0]    py,
   input  logic [SCALAR_BITS-1:0]   scalar_raw,
   output ecsm_pkg::status_type     status,
   output logic [FIELD_BITS-1:0]    acc_x,
   output logic [FIELD_BITS-1:0]    acc_y
);
   import ecsm_pkg::*;

   localparam int CNT_BITS = $clog2(FIELD_BITS + 1);

   logic [FIELD_BITS-1:0] a_ff, bx_ff, by_ff, ax_ff, ay_ff, t0_ff, t1_ff, t2_ff;
   logic [FIELD_BITS-1:0] lam_ff, r0_ff, r1_ff, s0_ff, s1_ff, q_ff;
   logic [SCALAR_BITS-1:0] mag_ff;
   logic neg_ff;

   logic mul_run_ff, mul_run_in, div_run_ff, div_run_in;
   logic [FIELD_BITS-1:0] mul_acc_ff, mul_u_ff, mul_v_ff;
   logic [FIELD_BITS-1:0] rem_ff, quo_ff, dvs_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [4:0]            dst_ff;

   logic [FIELD_BITS-1:0] opa, opb, imm, wr_data;
   logic [4:0]            wr_sel;
   logic                  wr_en, q_load, imm_op;
   logic [FIELD_BITS:0]   div_trial, div_diff;
   logic                  div_fits;
   logic [FIELD_BITS-1:0] rem_next, quo_next, mul_acc_next, mul_u_next;

   function automatic logic [FIELD_BITS-1:0] add_mod(input logic [FIELD_BITS-1:0] u,
                                                     input logic [FIELD_BITS-1:0] v,
                                                     input logic [FIELD_BITS-1:0] p);
      logic [FIELD_BITS:0] sum;
      sum = {1'b0, u} + {1'b0, v};
      if (sum >= {1'b0, p}) begin
         sum = sum - {1'b0, p};
      end
      return sum[FIELD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] sub_mod(input logic [FIELD_BITS-1:0] u,
                                                     input logic [FIELD_BITS-1:0] v,
                                                     input logic [FIELD_BITS-1:0] p);
      logic [FIELD_BITS:0] dif;
      if (u >= v) begin
         dif = {1'b0, u} - {1'b0, v};
      end else begin
         dif = {1'b0, u} + {1'b0, p} - {1'b0, v};
      end
      return dif[FIELD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] read_reg(input logic [4:0] sel,
      input logic [FIELD_BITS-1:0] p, input logic [FIELD_BITS-1:0] ca,
      input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] bx,
      input logic [FIELD_BITS-1:0] by, input logic [FIELD_BITS-1:0] ax,
      input logic [FIELD_BITS-1:0] ay, input logic [FIELD_BITS-1:0] t0,
      input logic [FIELD_BITS-1:0] t1, input logic [FIELD_BITS-1:0] t2,
      input logic [FIELD_BITS-1:0] lam, input logic [FIELD_BITS-1:0] r0,
      input logic [FIELD_BITS-1:0] r1, input logic [FIELD_BITS-1:0] s0,
      input logic [FIELD_BITS-1:0] s1, input logic [FIELD_BITS-1:0] q);
      logic [FIELD_BITS-1:0] val;
      case (sel)
         REG_P:   val = p;
         REG_CA:  val = ca;
         REG_A:   val = a;
         REG_BX:  val = bx;
         REG_BY:  val = by;
         REG_AX:  val = ax;
         REG_AY:  val = ay;
         REG_T0:  val = t0;
         REG_T1:  val = t1;
         REG_T2:  val = t2;
         REG_LAM: val = lam;
         REG_R0:  val = r0;
         REG_R1:  val = r1;
         REG_S0:  val = s0;
         REG_S1:  val = s1;
         REG_Q:   val = q;
         default: val = '0;
      endcase
      return val;
   endfunction

   always_comb begin
      opa = read_reg(cmd.src_a, prime, curve_a, a_ff, bx_ff, by_ff, ax_ff, ay_ff, t0_ff,
                     t1_ff, t2_ff, lam_ff, r0_ff, r1_ff, s0_ff, s1_ff, q_ff);
      opb = read_reg(cmd.src_b, prime, curve_a, a_ff, bx_ff, by_ff, ax_ff, ay_ff, t0_ff,
                     t1_ff, t2_ff, lam_ff, r0_ff, r1_ff, s0_ff, s1_ff, q_ff);
   end

   always_comb begin
      case (cmd.op)
         OP_ADD:  imm = add_mod(opa, opb, prime);
         OP_SUB:  imm = sub_mod(opa, opb, prime);
         OP_RED:  imm = (opa >= prime) ? opa - prime : opa;
         OP_ONE:  imm = FIELD_BITS'(1);
         default: imm = opa;
      endcase
      imm_op = cmd.op inside {OP_MOV, OP_ADD, OP_SUB, OP_RED, OP_ONE};
   end

   // serial steps
   always_comb begin
      div_trial    = {rem_ff, quo_ff[FIELD_BITS-1]};
      div_fits     = div_trial >= {1'b0, dvs_ff};
      div_diff     = div_trial - {1'b0, dvs_ff};
      rem_next     = div_fits ? div_diff[FIELD_BITS-1:0] : div_trial[FIELD_BITS-1:0];
      quo_next     = {quo_ff[FIELD_BITS-2:0], div_fits};
      mul_acc_next = mul_v_ff[0] ? add_mod(mul_acc_ff, mul_u_ff, prime) : mul_acc_ff;
      mul_u_next   = add_mod(mul_u_ff, mul_u_ff, prime);
   end

   always_comb begin
      wr_en      = 1'b0;
      wr_sel     = cmd.dst;
      wr_data    = imm;
      q_load     = 1'b0;
      mul_run_in = mul_run_ff;
      div_run_in = div_run_ff;
      if (cmd.go && imm_op) begin
         wr_en = 1'b1;
      end else if (mul_run_ff && mul_v_ff == '0) begin
         wr_en      = 1'b1;
         wr_sel     = dst_ff;
         wr_data    = mul_acc_ff;
         mul_run_in = 1'b0;
      end else if (div_run_ff && cnt_ff == '0) begin
         wr_en      = 1'b1;
         wr_sel     = dst_ff;
         wr_data    = rem_ff;
         q_load     = 1'b1;
         div_run_in = 1'b0;
      end
      if (cmd.go && cmd.op == OP_MUL) begin
         mul_run_in = 1'b1;
      end
      if (cmd.go && cmd.op == OP_DIV) begin
         div_run_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_run_ff <= 1'b0;
         div_run_ff <= 1'b0;
      end else begin
         mul_run_ff <= mul_run_in;
         div_run_ff <= div_run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go && cmd.op == OP_MUL) begin
         mul_acc_ff <= '0;
         mul_u_ff   <= opa;
         mul_v_ff   <= opb;
         dst_ff     <= cmd.dst;
      end else if (mul_run_ff && mul_v_ff != '0) begin
         mul_acc_ff <= mul_acc_next;
         mul_u_ff   <= mul_u_next;
         mul_v_ff   <= mul_v_ff >> 1;
      end
      if (cmd.go && cmd.op == OP_DIV) begin
         rem_ff <= '0;
         quo_ff <= opa;
         dvs_ff <= opb;
         cnt_ff <= CNT_BITS'(FIELD_BITS);
         dst_ff <= cmd.dst;
      end else if (div_run_ff && cnt_ff != '0) begin
         rem_ff <= rem_next;
         quo_ff <= quo_next;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // register file writes
   always_ff @(posedge clock) begin
      if (cmd.go && cmd.op == OP_LOAD) begin
         bx_ff  <= px;
         by_ff  <= py;
         neg_ff <= scalar_raw[SCALAR_BITS-1];
         mag_ff <= scalar_raw[SCALAR_BITS-1] ? (~scalar_raw + 1'b1) : scalar_raw;
      end else if (cmd.go && cmd.op == OP_SHIFT) begin
         mag_ff <= mag_ff >> 1;
      end
      if (q_load) begin
         q_ff <= quo_ff;
      end
      if (wr_en) begin
         case (wr_sel)
            REG_A:   a_ff   <= wr_data;
            REG_BX:  bx_ff  <= wr_data;
            REG_BY:  by_ff  <= wr_data;
            REG_AX:  ax_ff  <= wr_data;
            REG_AY:  ay_ff  <= wr_data;
            REG_T0:  t0_ff  <= wr_data;
            REG_T1:  t1_ff  <= wr_data;
            REG_T2:  t2_ff  <= wr_data;
            REG_LAM: lam_ff <= wr_data;
            REG_R0:  r0_ff  <= wr_data;
            REG_R1:  r1_ff  <= wr_data;
            REG_S0:  s0_ff  <= wr_data;
            REG_S1:  s1_ff  <= wr_data;
            REG_Q:   q_ff   <= wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      status.busy     = mul_run_ff | div_run_ff;
      status.a_zero   = (opa == '0);
      status.a_eq_b   = (opa == opb);
      status.mag_zero = (mag_ff == '0);
      status.mag_lsb  = mag_ff[0];
      status.neg      = neg_ff;
      status.p_small  = (prime < FIELD_BITS'(2));
   end

   assign acc_x = ax_ff;
   assign acc_y = ay_ff;

endmodule

@@ design/ecsm_ctrl.sv @@
// Sequencer for operand reduction, the scalar bit loop, point add, point double and the Euclidean inverse.
`timescale 1ns / 1ps
module ecsm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  point_inf,
   input  ecsm_pkg::status_type  status,
   output ecsm_pkg::cmd_type     cmd,
   output ecsm_pkg::report_type  report
);
   import ecsm_pkg::*;

   localparam logic [5:0] S_IDLE = 6'd0,  S_RED_A = 6'd1,  S_RED_X = 6'd2,  S_RED_Y = 6'd3;
   localparam logic [5:0] S_NEG  = 6'd4,  S_LOOP  = 6'd5,  S_ADD_CHK = 6'd6, S_CPX = 6'd7;
   localparam logic [5:0] S_CPY  = 6'd8,  S_ADD_CHKY = 6'd9, S_ADD_DY = 6'd10, S_ADD_DX = 6'd11;
   localparam logic [5:0] S_DBL_CHK = 6'd12, S_D1 = 6'd13, S_D2 = 6'd14, S_D3 = 6'd15;
   localparam logic [5:0] S_D4 = 6'd16, S_D5 = 6'd17, S_INV0 = 6'd18, S_INV1 = 6'd19;
   localparam logic [5:0] S_INV2 = 6'd20, S_INV3 = 6'd21, S_IL = 6'd22, S_IDIV = 6'd23;
   localparam logic [5:0] S_IRED = 6'd24, S_IMUL = 6'd25, S_ISUB = 6'd26, S_IM1 = 6'd27;
   localparam logic [5:0] S_IM2 = 6'd28, S_IM3 = 6'd29, S_IM4 = 6'd30, S_L1 = 6'd31;
   localparam logic [5:0] S_L2 = 6'd32, S_L3 = 6'd33, S_L4 = 6'd34, S_L5 = 6'd35;
   localparam logic [5:0] S_L6 = 6'd36, S_L7 = 6'd37, S_L8 = 6'd38, S_SHIFT = 6'd39;
   localparam logic [5:0] S_DONE = 6'd40;

   logic [5:0] state_ff, state_in;
   logic acc_inf_ff, acc_inf_in, base_inf_ff, base_inf_in;
   logic pt_acc_ff, pt_acc_in, dbl_ff, dbl_in;
   logic [4:0] x_id, y_id, x2_id;
   logic pt_inf;

   always_comb begin
      x_id   = pt_acc_ff ? REG_AX : REG_BX;
      y_id   = pt_acc_ff ? REG_AY : REG_BY;
      x2_id  = dbl_ff ? x_id : REG_BX;
      pt_inf = pt_acc_ff ? acc_inf_ff : base_inf_ff;
   end

   always_comb begin
      state_in    = state_ff;
      acc_inf_in  = acc_inf_ff;
      base_inf_in = base_inf_ff;
      pt_acc_in   = pt_acc_ff;
      dbl_in      = dbl_ff;
      cmd         = '0;
      cmd.op      = OP_NOP;
      report.busy       = (state_ff != S_IDLE);
      report.result_inf = acc_inf_ff;
      report.done       = 1'b0;
      if (!status.busy) begin
         case (state_ff)
            S_IDLE: begin
               cmd.op = OP_LOAD;
               cmd.go = start;
               if (start) begin
                  acc_inf_in  = 1'b1;
                  base_inf_in = 1'b0;
                  state_in    = (status.p_small || point_inf) ? S_DONE : S_RED_A;
               end
            end
            S_RED_A: begin
               cmd.op = OP_DIV; cmd.src_a = REG_CA; cmd.src_b = REG_P; cmd.dst = REG_A;
               cmd.go = 1'b1; state_in = S_RED_X;
            end
            S_RED_X: begin
               cmd.op = OP_DIV; cmd.src_a = REG_BX; cmd.src_b = REG_P; cmd.dst = REG_BX;
               cmd.go = 1'b1; state_in = S_RED_Y;
            end
            S_RED_Y: begin
               cmd.op = OP_DIV; cmd.src_a = REG_BY; cmd.src_b = REG_P; cmd.dst = REG_BY;
               cmd.go = 1'b1; state_in = S_NEG;
            end
            S_NEG: begin
               cmd.op = OP_SUB; cmd.src_a = REG_ZERO; cmd.src_b = REG_BY; cmd.dst = REG_BY;
               cmd.go = status.neg; state_in = S_LOOP;
            end
            S_LOOP: begin
               if (status.mag_zero) begin
                  state_in = S_DONE;
               end else if (status.mag_lsb) begin
                  state_in = S_ADD_CHK;
               end else begin
                  pt_acc_in = 1'b0; dbl_in = 1'b1; state_in = S_DBL_CHK;
               end
            end
            S_ADD_CHK: begin
               cmd.src_a = REG_AX; cmd.src_b = REG_BX;
               if (acc_inf_ff) begin
                  state_in = S_CPX;
               end else if (base_inf_ff) begin
                  pt_acc_in = 1'b0; dbl_in = 1'b1; state_in = S_DBL_CHK;
               end else if (status.a_eq_b) begin
                  state_in = S_ADD_CHKY;
               end else begin
                  pt_acc_in = 1'b1; dbl_in = 1'b0; state_in = S_ADD_DY;
               end
            end
            S_CPX: begin
               cmd.op = OP_MOV; cmd.src_a = REG_BX; cmd.dst = REG_AX;
               cmd.go = 1'b1; state_in = S_CPY;
            end
            S_CPY: begin
               cmd.op = OP_MOV; cmd.src_a = REG_BY; cmd.dst = REG_AY; cmd.go = 1'b1;
               acc_inf_in = base_inf_ff;
               pt_acc_in = 1'b0; dbl_in = 1'b1; state_in = S_DBL_CHK;
            end
            S_ADD_CHKY: begin
               cmd.src_a = REG_AY; cmd.src_b = REG_BY;
               if (status.a_eq_b) begin
                  pt_acc_in = 1'b1; dbl_in = 1'b1;
               end else begin
                  acc_inf_in = 1'b1; pt_acc_in = 1'b0; dbl_in = 1'b1;
               end
               state_in = S_DBL_CHK;
            end
            S_ADD_DY: begin
               cmd.op = OP_SUB; cmd.src_a = REG_BY; cmd.src_b = REG_AY; cmd.dst = REG_T1;
               cmd.go = 1'b1; state_in = S_ADD_DX;
            end
            S_ADD_DX: begin
               cmd.op = OP_SUB; cmd.src_a = REG_BX; cmd.src_b = REG_AX; cmd.dst = REG_T0;
               cmd.go = 1'b1; state_in = S_INV0;
            end
            S_DBL_CHK: begin
               cmd.src_a = y_id;
               if (pt_inf || status.a_zero) begin
                  if (pt_acc_ff) begin
                     acc_inf_in = 1'b1; pt_acc_in = 1'b0; dbl_in = 1'b1;
                     state_in = S_DBL_CHK;
                  end else begin
                     base_inf_in = 1'b1; state_in = S_SHIFT;
                  end
               end else begin
                  state_in = S_D1;
               end
            end
            S_D1: begin
               cmd.op = OP_MUL; cmd.src_a = x_id; cmd.src_b = x_id; cmd.dst = REG_T0;
               cmd.go = 1'b1; state_in = S_D2;
            end
            S_D2: begin
               cmd.op = OP_ADD; cmd.src_a = REG_T0; cmd.src_b = REG_T0; cmd.dst = REG_T1;
               cmd.go = 1'b1; state_in = S_D3;
            end
            S_D3: begin
               cmd.op = OP_ADD; cmd.src_a = REG_T1; cmd.src_b = REG_T0; cmd.dst = REG_T1;
               cmd.go = 1'b1; state_in = S_D4;
            end
            S_D4: begin
               cmd.op = OP_ADD; cmd.src_a = REG_T1; cmd.src_b = REG_A; cmd.dst = REG_T1;
               cmd.go = 1'b1; state_in = S_D5;
            end
            S_D5: begin
               cmd.op = OP_ADD; cmd.src_a = y_id; cmd.src_b = y_id; cmd.dst = REG_T0;
               cmd.go = 1'b1; state_in = S_INV0;
            end
            S_INV0: begin
               cmd.op = OP_DIV; cmd.src_a = REG_T0; cmd.src_b = REG_P; cmd.dst = REG_R0;
               cmd.go = 1'b1; state_in = S_INV1;
            end
            S_INV1: begin
               cmd.op = OP_MOV; cmd.src_a = REG_P; cmd.dst = REG_R1;
               cmd.go = 1'b1; state_in = S_INV2;
            end
            S_INV2: begin
               cmd.op = OP_ONE; cmd.dst = REG_S0; cmd.go = 1'b1; state_in = S_INV3;
            end
            S_INV3: begin
               cmd.op = OP_MOV; cmd.src_a = REG_ZERO; cmd.dst = REG_S1;
               cmd.go = 1'b1; state_in = S_IL;
            end
            S_IL: begin
               cmd.src_a = REG_R1;
               state_in = status.a_zero ? S_L1 : S_IDIV;
            end
            S_IDIV: begin
               cmd.op = OP_DIV; cmd.src_a = REG_R0; cmd.src_b = REG_R1; cmd.dst = REG_T2;
               cmd.go = 1'b1; state_in = S_IRED;
            end
            S_IRED: begin
               cmd.op = OP_RED; cmd.src_a = REG_Q; cmd.dst = REG_Q;
               cmd.go = 1'b1; state_in = S_IMUL;
            end
            S_IMUL: begin
               cmd.op = OP_MUL; cmd.src_a = REG_Q; cmd.src_b = REG_S1; cmd.dst = REG_Q;
               cmd.go = 1'b1; state_in = S_ISUB;
            end
            S_ISUB: begin
               cmd.op = OP_SUB; cmd.src_a = REG_S0; cmd.src_b = REG_Q; cmd.dst = REG_Q;
               cmd.go = 1'b1; state_in = S_IM1;
            end
            S_IM1: begin
               cmd.op = OP_MOV; cmd.src_a = REG_R1; cmd.dst = REG_R0;
               cmd.go = 1'b1; state_in = S_IM2;
            end
            S_IM2: begin
               cmd.op = OP_MOV; cmd.src_a = REG_T2; cmd.dst = REG_R1;
               cmd.go = 1'b1; state_in = S_IM3;
            end
            S_IM3: begin
               cmd.op = OP_MOV; cmd.src_a = REG_S1; cmd.dst = REG_S0;
               cmd.go = 1'b1; state_in = S_IM4;
            end
            S_IM4: begin
               cmd.op = OP_MOV; cmd.src_a = REG_Q; cmd.dst = REG_S1;
               cmd.go = 1'b1; state_in = S_IL;
            end
            S_L1: begin
               cmd.op = OP_MUL; cmd.src_a = REG_T1; cmd.src_b = REG_S0; cmd.dst = REG_LAM;
               cmd.go = 1'b1; state_in = S_L2;
            end
            S_L2: begin
               cmd.op = OP_MUL; cmd.src_a = REG_LAM; cmd.src_b = REG_LAM; cmd.dst = REG_T0;
               cmd.go = 1'b1; state_in = S_L3;
            end
            S_L3: begin
               cmd.op = OP_SUB; cmd.src_a = REG_T0; cmd.src_b = x_id; cmd.dst = REG_T0;
               cmd.go = 1'b1; state_in = S_L4;
            end
            S_L4: begin
               cmd.op = OP_SUB; cmd.src_a = REG_T0; cmd.src_b = x2_id; cmd.dst = REG_T0;
               cmd.go = 1'b1; state_in = S_L5;
            end
            S_L5: begin
               cmd.op = OP_SUB; cmd.src_a = x_id; cmd.src_b = REG_T0; cmd.dst = REG_T1;
               cmd.go = 1'b1; state_in = S_L6;
            end
            S_L6: begin
               cmd.op = OP_MUL; cmd.src_a = REG_LAM; cmd.src_b = REG_T1; cmd.dst = REG_T1;
               cmd.go = 1'b1; state_in = S_L7;
            end
            S_L7: begin
               cmd.op = OP_SUB; cmd.src_a = REG_T1; cmd.src_b = y_id; cmd.dst = y_id;
               cmd.go = 1'b1; state_in = S_L8;
            end
            S_L8: begin
               cmd.op = OP_MOV; cmd.src_a = REG_T0; cmd.dst = x_id; cmd.go = 1'b1;
               if (pt_acc_ff) begin
                  acc_inf_in = 1'b0; pt_acc_in = 1'b0; dbl_in = 1'b1;
                  state_in = S_DBL_CHK;
               end else begin
                  base_inf_in = 1'b0; state_in = S_SHIFT;
               end
            end
            S_SHIFT: begin
               cmd.op = OP_SHIFT; cmd.go = 1'b1; state_in = S_LOOP;
            end
            S_DONE: begin
               report.done = 1'b1; state_in = S_IDLE;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         acc_inf_ff  <= 1'b1;
         base_inf_ff <= 1'b0;
         pt_acc_ff   <= 1'b0;
         dbl_ff      <= 1'b1;
      end else begin
         state_ff    <= state_in;
         acc_inf_ff  <= acc_inf_in;
         base_inf_ff <= base_inf_in;
         pt_acc_ff   <= pt_acc_in;
         dbl_ff      <= dbl_in;
      end
   end

endmodule
